[sv/well_recurrence_generator_defines.svh]
// Assertion macros for the WELL recurrence generator.
`ifndef WELL_RECURRENCE_GENERATOR_DEFINES_SVH
`define WELL_RECURRENCE_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define WRG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");
`define WRG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");
`else
`define WRG_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define WRG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[sv/wrg_pkg.sv]
`timescale 1ns / 1ps
package wrg_pkg;

  localparam int unsigned RING_WORDS = 16;
  localparam int unsigned SPLIT_BITS = 0;
  localparam int unsigned TAP_ONE    = 13;
  localparam int unsigned TAP_TWO    = 9;
  localparam int unsigned TAP_THREE  = 5;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned PTR_W     = $clog2(RING_WORDS);
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned SLOT_W    = 52;
  localparam int unsigned CFG_IDX_W = $clog2(NUM_SLOTS);

  localparam int unsigned TAP1_POS = TAP_ONE % RING_WORDS;
  localparam int unsigned TAP2_POS = TAP_TWO % RING_WORDS;
  localparam int unsigned TAP3_POS = TAP_THREE % RING_WORDS;

  localparam logic [WORD_W-1:0] SPLIT_MASK =
    (SPLIT_BITS >= WORD_W) ? {WORD_W{1'b1}} :
    WORD_W'((64'd1 << SPLIT_BITS) - 64'd1);

  typedef enum logic [2:0] {
    CLS_ZERO   = 3'd0,
    CLS_IDENT  = 3'd1,
    CLS_SHIFT  = 3'd2,
    CLS_XSHIFT = 3'd3,
    CLS_TWIST  = 3'd4,
    CLS_MASKSH = 3'd5,
    CLS_ROTATE = 3'd6
  } wrg_class_t;

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_LOAD = 1'b1
  } wrg_op_t;

  typedef struct packed {
    logic [WORD_W-1:0] mask;
    logic [4:0]        s;
    logic [4:0]        q;
    logic [6:0]        t;
    logic [2:0]        cls;
  } wrg_slot_t;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] seed_word;
  } wrg_item_t;

endpackage

[sv/wrg_transform.sv]
`timescale 1ns / 1ps
module wrg_transform import wrg_pkg::*; (
  input  wrg_slot_t         slot,
  input  logic [WORD_W-1:0] x,
  output logic [WORD_W-1:0] y
);

  logic [6:0]          mag;
  logic                big;
  logic [WORD_W-1:0]   shifted;
  logic [2*WORD_W-1:0] rot_wide;
  logic [WORD_W-1:0]   rot;
  logic [WORD_W-1:0]   clr;

  assign mag      = slot.t[6] ? (~slot.t + 7'd1) : slot.t;
  assign big      = mag[6] | mag[5];
  assign shifted  = big ? '0 : (slot.t[6] ? (x << mag[4:0]) : (x >> mag[4:0]));
  assign rot_wide = {x, x} << slot.q;
  assign rot      = rot_wide[2*WORD_W-1:WORD_W];
  assign clr      = ~(WORD_W'(1) << (~slot.s));

  always_comb begin
    case (wrg_class_t'(slot.cls))
      CLS_ZERO:   y = '0;
      CLS_IDENT:  y = x;
      CLS_SHIFT:  y = shifted;
      CLS_XSHIFT: y = x ^ shifted;
      CLS_TWIST:  y = (x >> 1) ^ (x[0] ? slot.mask : '0);
      CLS_MASKSH: y = x ^ (shifted & slot.mask);
      CLS_ROTATE: y = (rot & clr) ^ (x[~slot.t[4:0]] ? slot.mask : '0);
      default:    y = x;
    endcase
  end

endmodule

[sv/wrg_ring.sv]
`timescale 1ns / 1ps
module wrg_ring import wrg_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  wrg_item_t                     item,
  input  wrg_slot_t [NUM_SLOTS-1:0]     slots,
  output logic [WORD_W-1:0]             next_word
);

  // words[k] holds ring entry (pointer + k) mod RING_WORDS
  logic [WORD_W-1:0] words      [RING_WORDS];
  logic [WORD_W-1:0] words_next [RING_WORDS];
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  ptr_next;

  logic [WORD_W-1:0] tin  [NUM_SLOTS];
  logic [WORD_W-1:0] tout [NUM_SLOTS];
  logic [WORD_W-1:0] z0, z1, z2, z3, z4;

  assign z0 = (words[RING_WORDS-1] & ~SPLIT_MASK) | (words[RING_WORDS-2] & SPLIT_MASK);
  assign z1 = tout[0] ^ tout[1];
  assign z2 = tout[2] ^ tout[3];
  assign z3 = z1 ^ z2;
  assign z4 = tout[4] ^ tout[5] ^ tout[6] ^ tout[7];

  assign tin[0] = words[0];
  assign tin[1] = words[TAP1_POS];
  assign tin[2] = words[TAP2_POS];
  assign tin[3] = words[TAP3_POS];
  assign tin[4] = z0;
  assign tin[5] = z1;
  assign tin[6] = z2;
  assign tin[7] = z3;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    wrg_transform u_transform (
      .slot (slots[g]),
      .x    (tin[g]),
      .y    (tout[g])
    );
  end

  always_comb begin
    logic [PTR_W:0] src;
    src = '0;
    for (int k = 0; k < RING_WORDS; k++) begin
      words_next[k] = words[k];
    end
    ptr_next  = ptr;
    next_word = z4;
    case (wrg_op_t'(item.opcode))
      OP_STEP: begin
        words_next[0] = z4;
        words_next[1] = z3;
        for (int k = 2; k < RING_WORDS; k++) begin
          words_next[k] = words[k-1];
        end
        ptr_next  = (ptr == '0) ? PTR_W'(RING_WORDS - 1) : ptr - PTR_W'(1);
        next_word = z4;
      end
      OP_LOAD: begin
        // realign to absolute order, since the pointer returns to zero
        for (int k = 0; k < RING_WORDS; k++) begin
          src = (PTR_W+1)'(k) + (PTR_W+1)'(RING_WORDS) - {1'b0, ptr};
          if (src >= (PTR_W+1)'(RING_WORDS)) begin
            src = src - (PTR_W+1)'(RING_WORDS);
          end
          words_next[k] = (item.word_index == IDX_W'(k)) ? item.seed_word
                                                          : words[src[PTR_W-1:0]];
        end
        ptr_next  = '0;
        next_word = item.seed_word;
      end
      default: begin
        next_word = z4;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      for (int k = 0; k < RING_WORDS; k++) begin
        words[k] <= '0;
      end
    end else if (go) begin
      ptr <= ptr_next;
      for (int k = 0; k < RING_WORDS; k++) begin
        words[k] <= words_next[k];
      end
    end
  end

endmodule

[sv/well_recurrence_generator.sv]
`timescale 1ns / 1ps
`include "well_recurrence_generator_defines.svh"
// WELL recurrence generator, 32-bit words, eight configurable transform slots.
// Input channel (in_valid / in_stall): opcode 0 steps the recurrence, opcode 1
// loads seed_word into ring entry word_index and returns the pointer to zero.
// Output channel (out_valid / out_stall): one out_word per input item, in order:
// the new word after a step, the seed word after a load.
// Configuration: cfg_write with cfg_index 0..7 writes slot cfg_index from
// cfg_data; write only while no item is in flight.
// An accepted item waits in the input register; the ring update and the result
// register then happen in the same cycle, once the output is not stalled.
// Throughput is one item per cycle while the output is not stalled.
// Reset clears the ring, pointer, slots and both valid registers.
// While out_stall holds a full result register, the input register holds its
// item and in_stall rises; nothing is dropped.
module well_recurrence_generator import wrg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [IDX_W-1:0]      word_index,
  input  logic [WORD_W-1:0]     seed_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_W-1:0]     out_word,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SLOT_W-1:0]     cfg_data
);

  wrg_slot_t [NUM_SLOTS-1:0] slots;
  wrg_item_t                 in_item;
  logic                      in_full;
  logic                      advance;
  logic                      accept;
  logic [WORD_W-1:0]         next_word;

  assign advance  = in_full && !(out_valid && out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= '0;
    end else if (cfg_write) begin
      slots[cfg_index] <= wrg_slot_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= '{opcode: opcode, word_index: word_index, seed_word: seed_word};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= next_word;
    end
  end

  wrg_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .item      (in_item),
    .slots     (slots),
    .next_word (next_word)
  );

  `WRG_ASSERT_SAME(a_stall_cause, clk, rst, in_stall, out_valid && out_stall && in_full)
  `WRG_ASSERT_NEXT(a_load_echo, clk, rst, advance && in_item.opcode == OP_LOAD, out_valid && out_word == $past(in_item.seed_word))
  `WRG_ASSERT_NEXT(a_drain, clk, rst, out_valid && !out_stall && !in_full, !out_valid)

endmodule

[dv/well_recurrence_generator_tb.sv]
`timescale 1ns / 1ps
module well_recurrence_generator_tb;
  import wrg_pkg::*;

  localparam logic [2:0] CLS_SPARE    = 3'd7;
  localparam int         ITEM_TARGET  = 1300;
  localparam int         QUIET_LIMIT  = 1000;
  localparam int         SETTLE_TICKS = 10;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 opcode;
  logic [IDX_W-1:0]     word_index;
  logic [WORD_W-1:0]    seed_word;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_W-1:0]    out_word;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SLOT_W-1:0]    cfg_data;

  logic [WORD_W-1:0] ring_model [RING_WORDS];
  int                ring_ptr;
  wrg_slot_t         slot_model [NUM_SLOTS];
  wrg_slot_t         cfg_set [NUM_SLOTS];
  logic [WORD_W-1:0] pending_words [$];
  logic [WORD_W-1:0] want_word;
  int                errors;
  int                items_sent;
  int                stall_left;
  int                quiet_cycles;
  bit                tx_idle;
  bit                rx_idle;

  well_recurrence_generator dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .word_index (word_index),
    .seed_word  (seed_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] shift_signed(logic [WORD_W-1:0] x, logic [6:0] t);
    int amt;
    amt = $signed(t);
    if (amt > 0) return (amt >= 32) ? '0 : (x >> amt);
    if (amt < 0) return (amt <= -32) ? '0 : (x << (-amt));
    return x;
  endfunction

  function automatic logic [WORD_W-1:0] apply_slot(wrg_slot_t sl, logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] rot;
    logic [WORD_W-1:0] clr;
    case (sl.cls)
      CLS_ZERO:   return '0;
      CLS_IDENT:  return x;
      CLS_SHIFT:  return shift_signed(x, sl.t);
      CLS_XSHIFT: return x ^ shift_signed(x, sl.t);
      CLS_TWIST:  return x[0] ? ((x >> 1) ^ sl.mask) : (x >> 1);
      CLS_MASKSH: return x ^ (shift_signed(x, sl.t) & sl.mask);
      CLS_ROTATE: begin
        rot = (sl.q == 0) ? x : ((x << sl.q) | (x >> (32 - sl.q)));
        clr = ~(32'd1 << (31 - sl.s));
        return (rot & clr) ^ (x[31 - sl.t[4:0]] ? sl.mask : '0);
      end
      default:    return x;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] advance_model(wrg_op_t op, logic [IDX_W-1:0] idx,
                                                      logic [WORD_W-1:0] seed);
    int back1;
    logic [WORD_W-1:0] z0, z1, z2, z3, z4;
    if (op == OP_LOAD) begin
      if (idx < RING_WORDS) ring_model[idx] = seed;
      ring_ptr = 0;
      return seed;
    end
    back1 = (ring_ptr + RING_WORDS - 1) % RING_WORDS;
    z0 = (ring_model[back1] & ~SPLIT_MASK) |
         (ring_model[(ring_ptr + RING_WORDS - 2) % RING_WORDS] & SPLIT_MASK);
    z1 = apply_slot(slot_model[0], ring_model[ring_ptr]) ^
         apply_slot(slot_model[1], ring_model[(ring_ptr + TAP_ONE) % RING_WORDS]);
    z2 = apply_slot(slot_model[2], ring_model[(ring_ptr + TAP_TWO) % RING_WORDS]) ^
         apply_slot(slot_model[3], ring_model[(ring_ptr + TAP_THREE) % RING_WORDS]);
    z3 = z1 ^ z2;
    z4 = apply_slot(slot_model[4], z0) ^ apply_slot(slot_model[5], z1) ^
         apply_slot(slot_model[6], z2) ^ apply_slot(slot_model[7], z3);
    ring_model[back1] = z4;
    ring_model[ring_ptr] = z3;
    ring_ptr = back1;
    return ring_model[ring_ptr];
  endfunction

  function automatic wrg_slot_t make_slot(logic [2:0] cls, logic [6:0] t, logic [4:0] q,
                                          logic [4:0] s, logic [WORD_W-1:0] mask);
    wrg_slot_t sl;
    sl.cls  = cls;
    sl.t    = t;
    sl.q    = q;
    sl.s    = s;
    sl.mask = mask;
    return sl;
  endfunction

  function automatic wrg_slot_t random_slot();
    wrg_slot_t sl;
    sl.cls  = 3'($urandom_range(0, 7));
    sl.q    = 5'($urandom);
    sl.s    = 5'($urandom);
    sl.mask = $urandom;
    if ($urandom_range(0, 3) == 0) sl.t = 7'($urandom);
    else sl.t = 7'(int'($urandom_range(0, 40)) - 20);
    return sl;
  endfunction

  task automatic send_item(wrg_op_t op, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] seed);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    word_index <= idx;
    seed_word  <= seed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_words = {pending_words, advance_model(op, idx, seed)};
    items_sent++;
  endtask

  task automatic send_step();
    send_item(OP_STEP, 6'($urandom), $urandom);
  endtask

  // hold off input until every outstanding item has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_config();
    for (int k = 0; k < NUM_SLOTS; k++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= cfg_set[k];
      slot_model[k] = cfg_set[k];
      @(negedge clk);
      cfg_write <= 1'b0;
    end
  endtask

  task automatic seed_ring();
    for (int k = 0; k < RING_WORDS; k++) send_item(OP_LOAD, IDX_W'(k), $urandom);
  endtask

  task automatic test_reset_state();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_step();
    send_step();
    send_item(OP_LOAD, 6'd3, 32'h1234_5678);
  endtask

  task automatic test_load_extremes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_item(OP_LOAD, 6'd0, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 6'd15, 32'h0000_0000);
    send_item(OP_LOAD, 6'd16, 32'hA5A5_A5A5);
    send_item(OP_LOAD, 6'd63, 32'h5A5A_5A5A);
    send_item(OP_LOAD, 6'd13, 32'h8000_0001);
  endtask

  task automatic test_shift_extremes();
    drain_results();
    cfg_set[0] = make_slot(CLS_XSHIFT, 7'h60, 5'd0, 5'd0, '0);
    cfg_set[1] = make_slot(CLS_MASKSH, 7'h20, 5'd0, 5'd0, 32'hFFFF_FFFF);
    cfg_set[2] = make_slot(CLS_SHIFT, 7'h61, 5'd0, 5'd0, '0);
    cfg_set[3] = make_slot(CLS_SHIFT, 7'h1F, 5'd0, 5'd0, '0);
    cfg_set[4] = make_slot(CLS_TWIST, 7'h00, 5'd0, 5'd0, 32'hFFFF_FFFF);
    cfg_set[5] = make_slot(CLS_XSHIFT, 7'h40, 5'd0, 5'd0, '0);
    cfg_set[6] = make_slot(CLS_MASKSH, 7'h3F, 5'd0, 5'd0, 32'h9908_B0DF);
    cfg_set[7] = make_slot(CLS_SPARE, 7'h00, 5'd0, 5'd0, '0);
    load_config();
    send_item(OP_LOAD, 6'd9, 32'hDEAD_BEEF);
    send_item(OP_LOAD, 6'd5, 32'h0F0F_F0F0);
    repeat (4) send_step();
  endtask

  task automatic test_rotate_classes();
    drain_results();
    cfg_set[0] = make_slot(CLS_ROTATE, 7'h7F, 5'd31, 5'd0, 32'hFFFF_FFFF);
    cfg_set[1] = make_slot(CLS_ROTATE, 7'h00, 5'd0, 5'd31, 32'hC0DE_CAFE);
    cfg_set[2] = make_slot(CLS_ZERO, 7'h7F, 5'd31, 5'd31, 32'hFFFF_FFFF);
    cfg_set[3] = make_slot(CLS_IDENT, 7'h00, 5'd0, 5'd0, '0);
    cfg_set[4] = make_slot(CLS_ROTATE, 7'h20, 5'd1, 5'd15, 32'h1357_9BDF);
    cfg_set[5] = make_slot(CLS_TWIST, 7'h00, 5'd0, 5'd0, 32'hE6A6_4D00);
    cfg_set[6] = make_slot(CLS_IDENT, 7'h00, 5'd0, 5'd0, '0);
    cfg_set[7] = make_slot(CLS_ROTATE, 7'h45, 5'd16, 5'd7, 32'h0000_0001);
    load_config();
    send_item(OP_LOAD, 6'd1, 32'h7FFF_FFFE);
    repeat (5) send_step();
  endtask

  task automatic test_random_phases();
    int phase;
    int count;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (phase == 0) cfg_set[k] = wrg_slot_t'({SLOT_W{1'b1}});
        else if (phase == 1) cfg_set[k] = '0;
        else cfg_set[k] = random_slot();
      end
      load_config();
      tx_idle = (phase != 0) && ($urandom_range(0, 2) != 0);
      rx_idle = (phase != 0) && ($urandom_range(0, 2) != 0);
      if (phase < 2 || $urandom_range(0, 5) != 0) seed_ring();
      count = $urandom_range(80, 160);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 99) < 88) send_step();
        else send_item(OP_LOAD, 6'($urandom), $urandom);
      end
      phase++;
    end
  endtask

  // result side: draw a stall run after each accepted result
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          errors++;
          $display("%0t: out_word expected none, actual %08h", $time, out_word);
        end else begin
          want_word = pending_words.pop_front();
          if (out_word !== want_word) begin
            errors++;
            $display("%0t: out_word expected %08h, actual %08h", $time, want_word, out_word);
          end
        end
        stall_left = rx_idle ? $urandom_range(0, 8) : 0;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    opcode     = OP_STEP;
    word_index = '0;
    seed_word  = '0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    errors     = 0;
    items_sent = 0;
    tx_idle    = 1'b0;
    rx_idle    = 1'b0;
    ring_ptr   = 0;
    for (int k = 0; k < RING_WORDS; k++) ring_model[k] = '0;
    for (int k = 0; k < NUM_SLOTS; k++) slot_model[k] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_load_extremes();
    test_shift_extremes();
    test_rotate_classes();
    test_random_phases();

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/wrg_pkg.sv
sv/wrg_transform.sv
sv/wrg_ring.sv
sv/well_recurrence_generator.sv
dv/well_recurrence_generator_tb.sv
